### hdl/ternary_first_match_lookup_core_macros.svh
// assertion helpers for the ternary first-match lookup core
`ifndef TERNARY_FIRST_MATCH_LOOKUP_CORE_MACROS_SVH
`define TERNARY_FIRST_MATCH_LOOKUP_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TFM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/tfm_pkg.sv
`default_nettype none

package tfm_pkg;

   localparam int PATTERN_W   = 16;
   localparam int ROW_INDEX_W = 6;
   localparam int MATCH_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int ROW_COUNT_W = 7;
   localparam int IN_COUNT_W  = 5;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 7'd0;
   localparam logic [IN_COUNT_W-1:0]  IN_COUNT_RESET  = 5'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT   = 2'd0,
      CSR_INPUT_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // one transaction as it moves from cell to cell
   typedef struct packed {
      logic                   valid;
      mode_type               mode;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [PATTERN_W-1:0]   value;
      logic [PATTERN_W-1:0]   care;
      logic                   found;
      logic [MATCH_W-1:0]     index;
   } stage_type;

endpackage

`default_nettype wire

### hdl/tfm_cell.sv
`default_nettype none

module tfm_cell #(
   parameter int CELL_INDEX = 0,
   parameter int STORE_W    = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                row_used,
   input  wire logic [STORE_W-1:0]  cmp_mask,
   input  wire tfm_pkg::stage_type  stage_in,
   output tfm_pkg::stage_type       stage_out
);

   localparam logic [tfm_pkg::MATCH_W-1:0] HIT_INDEX =
      tfm_pkg::MATCH_W'(CELL_INDEX % (1 << tfm_pkg::MATCH_W));

   logic [STORE_W-1:0] row_value_ff;
   logic [STORE_W-1:0] row_care_ff;
   tfm_pkg::stage_type stage_ff;
   tfm_pkg::stage_type stage_in_next;

   logic [STORE_W-1:0] q_care;
   logic [STORE_W-1:0] q_value;
   logic [STORE_W-1:0] row_cmp;
   logic [STORE_W-1:0] bad;
   logic               write_here;
   logic               match;

   always_comb begin
      q_care     = stage_in.care[STORE_W-1:0];
      q_value    = stage_in.value[STORE_W-1:0] & q_care;
      write_here = stage_in.valid && (stage_in.mode == tfm_pkg::MODE_WRITE)
                   && (32'(stage_in.row_index) == CELL_INDEX);
      row_cmp    = row_care_ff & cmp_mask;
      // a cared row position needs a cared query bit of the same value
      bad        = (row_cmp & ~q_care) | (row_cmp & (row_value_ff ^ q_value));
      match      = stage_in.valid && (stage_in.mode == tfm_pkg::MODE_QUERY)
                   && row_used && (bad == '0);

      stage_in_next = stage_in;
      if (!stage_in.found && match) begin
         stage_in_next.found = 1'b1;
         stage_in_next.index = HIT_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write_here) begin
         row_value_ff <= q_value;
         row_care_ff  <= q_care;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

### hdl/ternary_first_match_lookup_core.sv
// path: a request passes the row cells in order, one cell per row, then the response register
// throughput: one transaction per cycle while no stalled response waits; each row cell
//   passes it on whenever the chain advances
// reset: clears the in-flight valid flags, row_count to 0 and input_count to 16;
//   stored rows are not cleared and hold garbage until written
`default_nettype none
`include "ternary_first_match_lookup_core_macros.svh"

module ternary_first_match_lookup_core #(
   parameter int ROWS       = 64,
   parameter int INPUT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic [tfm_pkg::ROW_INDEX_W-1:0]     req_row_index,
   input  wire logic [tfm_pkg::PATTERN_W-1:0]       req_pattern_value,
   input  wire logic [tfm_pkg::PATTERN_W-1:0]       req_pattern_care,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [tfm_pkg::MATCH_W-1:0]              rsp_match_index,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tfm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tfm_pkg::CSR_DATA_W-1:0]      csr_data
);

   // positions above the pattern width are never cared, so they need no storage
   localparam int STORE_W = (INPUT_BITS < tfm_pkg::PATTERN_W) ? INPUT_BITS
                                                               : tfm_pkg::PATTERN_W;
   localparam logic [tfm_pkg::MATCH_W-1:0] ROWS_INDEX =
      tfm_pkg::MATCH_W'(ROWS % (1 << tfm_pkg::MATCH_W));

   logic [tfm_pkg::ROW_COUNT_W-1:0] row_count_ff;
   logic [tfm_pkg::IN_COUNT_W-1:0]  input_count_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            rsp_hit_ff;
   logic                            rsp_hit_in;
   logic [tfm_pkg::MATCH_W-1:0]     rsp_index_ff;
   logic [tfm_pkg::MATCH_W-1:0]     rsp_index_in;
   logic [tfm_pkg::MATCH_W-1:0]     miss_index;

   logic                advance;
   logic [STORE_W-1:0]  cmp_mask;
   logic [ROWS-1:0]     row_used;
   tfm_pkg::stage_type  head;
   tfm_pkg::stage_type  stage_q [ROWS];
   tfm_pkg::stage_type  tail;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= tfm_pkg::ROW_COUNT_RESET;
         input_count_ff <= tfm_pkg::IN_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tfm_pkg::CSR_ROW_COUNT:   row_count_ff   <= csr_data[tfm_pkg::ROW_COUNT_W-1:0];
            tfm_pkg::CSR_INPUT_COUNT: input_count_ff <= csr_data[tfm_pkg::IN_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < STORE_W; i++) begin
         cmp_mask[i] = (tfm_pkg::IN_COUNT_W'(i) < input_count_ff);
      end
   end

   assign miss_index = (32'(row_count_ff) > ROWS) ? ROWS_INDEX : row_count_ff;

   // the whole chain moves together; it holds only while a response waits and is stalled
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      head           = '0;
      head.valid     = req_valid;
      head.mode      = tfm_pkg::mode_type'(req_mode);
      head.row_index = req_row_index;
      head.value     = req_pattern_value;
      head.care      = req_pattern_care;
      head.found     = 1'b0;
      head.index     = '0;
   end

   for (genvar g = 0; g < ROWS; g++) begin : g_cell
      assign row_used[g] = (32'(row_count_ff) > g);

      tfm_cell #(
         .CELL_INDEX (g),
         .STORE_W    (STORE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .row_used  (row_used[g]),
         .cmp_mask  (cmp_mask),
         .stage_in  ((g == 0) ? head : stage_q[(g == 0) ? 0 : g - 1]),
         .stage_out (stage_q[g])
      );
   end

   assign tail = stage_q[ROWS-1];

   // response register
   always_comb begin
      rsp_valid_in = tail.valid && (tail.mode == tfm_pkg::MODE_QUERY);
      rsp_hit_in   = tail.found;
      rsp_index_in = tail.found ? tail.index : miss_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_index = rsp_index_ff;

   `TFM_ASSERT_NOW(a_hit_below_count, rsp_valid_ff && rsp_hit_ff, rsp_index_ff < miss_index, "hit index not below rows in use")
   `TFM_ASSERT_NOW(a_miss_reports_count, rsp_valid_ff && !rsp_hit_ff, rsp_index_ff == miss_index, "miss index differs from rows in use")
   `TFM_ASSERT_NOW(a_stall_only_when_full, req_stall, rsp_valid_ff && rsp_stall, "request stalled while response side is free")
   `TFM_ASSERT_NEXT(a_write_no_response, advance && !(tail.valid && tail.mode == tfm_pkg::MODE_QUERY), !rsp_valid_ff, "response produced without a query")

endmodule

`default_nettype wire
